// ===== src/wavetable_sound_chip_defines.svh =====
// ----------------------------------------------------------------------------
// Wavetable sound chip assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_SOUND_CHIP_DEFINES_SVH
`define WAVETABLE_SOUND_CHIP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define WTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// Wavetable sound chip package
// Sizes, request and register codes, the oscillator record and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

  localparam int RAM_DEPTH = 65536;
  localparam int NUM_OSC   = 32;
  localparam int SRAM_AW   = $clog2(RAM_DEPTH);
  localparam int OSC_AW    = $clog2(NUM_OSC);

  // request codes
  localparam logic [2:0] REQ_MODE   = 3'd0;
  localparam logic [2:0] REQ_PTR_LO = 3'd1;
  localparam logic [2:0] REQ_PTR_HI = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_SCAN   = 3'd5;

  // register page groups (pointer bits 7..5)
  localparam logic [2:0] GRP_FREQ_LO = 3'd0;
  localparam logic [2:0] GRP_FREQ_HI = 3'd1;
  localparam logic [2:0] GRP_VOLUME  = 3'd2;
  localparam logic [2:0] GRP_LAST    = 3'd3;
  localparam logic [2:0] GRP_BASE    = 3'd4;
  localparam logic [2:0] GRP_CONTROL = 3'd5;
  localparam logic [2:0] GRP_SIZE    = 3'd6;
  localparam logic [2:0] GRP_GLOBAL  = 3'd7;

  localparam logic [7:0] REG_IRQ_CLAIM = 8'hE0;
  localparam logic [7:0] REG_ENABLE    = 8'hE1;

  // window mode bits
  localparam int WM_RAM  = 6;
  localparam int WM_INCR = 5;

  // oscillator control bits and modes
  localparam int CTL_HALT   = 0;
  localparam int CTL_IRQ_EN = 3;
  localparam logic [1:0] MODE_FREE    = 2'd0;
  localparam logic [1:0] MODE_ONESHOT = 2'd1;
  localparam logic [1:0] MODE_SYNC    = 2'd2;
  localparam logic [1:0] MODE_SWAP    = 2'd3;

  typedef struct packed {
    logic [15:0] freq;
    logic [7:0]  vol;
    logic [16:0] base;
    logic [7:0]  ctl;
    logic [2:0]  size;
    logic [2:0]  res;
    logic [31:0] phase;
    logic [7:0]  last;
  } osc_rec_t;

  localparam int OSC_W = $bits(osc_rec_t);

  typedef struct packed {
    logic [16:0] addr;
    logic        pos_end;
    logic [31:0] span;
  } wts_calc_t;

  function automatic logic [SRAM_AW-1:0] snd_addr(input logic [16:0] a);
    snd_addr = a[SRAM_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/wavetable_sound_chip.sv =====
// ----------------------------------------------------------------------------
// Wavetable sound chip
// Thirty-two oscillator wavetable synthesiser behind a byte-wide bus window.
// ----------------------------------------------------------------------------
// Each input word is a window access (mode, pointer low/high, data write, data
// read) or a scan tick, and yields exactly one result word. Reads return the
// byte latched by the previous access. Sound RAM and the oscillator records
// live in two synchronous RAMs; all oscillator work is read, modify and write
// back through the single read port of the oscillator RAM, one access a cycle,
// so timing follows the number of record accesses. A bus access that reads
// sound RAM or touches an oscillator record takes longer than one that does
// not, and a control write that halts a running oscillator in one-shot or
// swap mode also runs the stop rules. A scan visits each visible oscillator
// in turn; a running one also reads sound RAM (and its partner above when a
// sync modulator), and a table end or a zero byte runs the stop rules. After
// reset a clearing pass writes zero to every sound RAM byte (RAM_DEPTH of
// them, 65536), with in_ready held low. Results sit in an output register,
// so the next word is taken while one waits.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_sound_chip (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_data_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data,
  output logic signed [21:0] out_mix_sample,
  output logic             out_sample_valid,
  output logic             out_irq_active
);

  import wts_pkg::*;

  `include "wavetable_sound_chip_defines.svh"

  // sequencer states
  localparam logic [4:0] ST_CLR     = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_EXEC    = 5'd2;
  localparam logic [4:0] ST_BUS_RD  = 5'd3;
  localparam logic [4:0] ST_RR_GOT  = 5'd4;
  localparam logic [4:0] ST_RW_GOT  = 5'd5;
  localparam logic [4:0] ST_SC_RD   = 5'd6;
  localparam logic [4:0] ST_SC_GOT  = 5'd7;
  localparam logic [4:0] ST_SC_BYTE = 5'd8;
  localparam logic [4:0] ST_SC_MIX  = 5'd9;
  localparam logic [4:0] ST_SY_RD   = 5'd10;
  localparam logic [4:0] ST_SY_GOT  = 5'd11;
  localparam logic [4:0] ST_SC_END  = 5'd12;
  localparam logic [4:0] ST_SP_M    = 5'd13;
  localparam logic [4:0] ST_SP_GOTM = 5'd14;
  localparam logic [4:0] ST_SP_P    = 5'd15;
  localparam logic [4:0] ST_SP_GOTP = 5'd16;
  localparam logic [4:0] ST_SP_FIN  = 5'd17;
  localparam logic [4:0] ST_DONE    = 5'd18;

  // control state
  logic [4:0]          state_r, state_nxt;
  logic [SRAM_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [15:0]         ptr_r, ptr_nxt;
  logic [6:0]          wmode_r, wmode_nxt;
  logic [7:0]          latch_r, latch_nxt;
  logic [7:0]          status_r, status_nxt;
  logic [7:0]          enable_r, enable_nxt;
  logic [5:0]          act_cnt_r, act_cnt_nxt;
  logic [NUM_OSC-1:0]  irq_r, irq_nxt;
  logic [NUM_OSC-1:0]  osc_vld_r, osc_vld_nxt;
  logic                osc_rvld_r;
  logic                out_valid_r, out_valid_nxt;

  // working payload
  logic [2:0]          req_r, req_nxt;
  logic [7:0]          din_r, din_nxt;
  logic [7:0]          reg_r, reg_nxt;
  logic [OSC_AW:0]     idx_r, idx_nxt;
  osc_rec_t            w_r, w_nxt;
  logic                pos_end_r, pos_end_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic signed [16:0]  prod_r, prod_nxt;
  logic signed [21:0]  mix_r, mix_nxt;
  logic [7:0]          res_rd_r, res_rd_nxt;
  logic                at_end_r, at_end_nxt;
  logic                from_reg_r, from_reg_nxt;
  logic [1:0]          pmode_r, pmode_nxt;
  logic [7:0]          out_rd_r, out_rd_nxt;
  logic signed [21:0]  out_mix_r, out_mix_nxt;
  logic                out_sv_r, out_sv_nxt;
  logic                out_irq_r, out_irq_nxt;

  // memory ports
  logic                osc_re, osc_we;
  logic [OSC_AW-1:0]   osc_raddr, osc_waddr;
  osc_rec_t            osc_wdata;
  logic [OSC_W-1:0]    osc_rdata;
  osc_rec_t            osc_q;
  logic                snd_re, snd_we;
  logic [SRAM_AW-1:0]  snd_raddr, snd_waddr;
  logic [7:0]          snd_wdata, snd_q;

  // helpers
  logic [5:0]          n_vis;
  logic [NUM_OSC-1:0]  vis_mask, claim_mask;
  logic                claim_hit;
  logic [OSC_AW-1:0]   claim_idx;
  logic [15:0]         ptr_step;
  logic [OSC_AW-1:0]   cur_idx, p_idx;
  logic                has_p, osc_ok, heavy;
  logic [1:0]          mode0, emode;
  logic signed [7:0]   b_s;
  logic signed [16:0]  prod_c;
  osc_rec_t            calc_in;
  wts_calc_t           calc;
  logic [7:0]          fin_ctl;
  logic [31:0]         fin_phase;
  logic                fin_irq;

  wts_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_snd_ram (
    .clk   (clk),
    .we    (snd_we),
    .waddr (snd_waddr),
    .wdata (snd_wdata),
    .re    (snd_re),
    .raddr (snd_raddr),
    .rdata (snd_q)
  );

  wts_ram #(.WIDTH(OSC_W), .DEPTH(NUM_OSC)) u_osc_ram (
    .clk   (clk),
    .we    (osc_we),
    .waddr (osc_waddr),
    .wdata (osc_wdata),
    .re    (osc_re),
    .raddr (osc_raddr),
    .rdata (osc_rdata)
  );

  // a record never written reads as its reset value, all zero
  assign osc_q = osc_rvld_r ? osc_rec_t'(osc_rdata) : '0;

  assign calc_in = (state_r == ST_SC_GOT) ? osc_q : w_r;

  wts_addr_gen u_addr_gen (
    .rec  (calc_in),
    .calc (calc)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rd_r;
  assign out_mix_sample   = out_mix_r;
  assign out_sample_valid = out_sv_r;
  assign out_irq_active   = out_irq_r;

  assign n_vis    = (act_cnt_r < 6'(NUM_OSC)) ? act_cnt_r : 6'(NUM_OSC);
  assign ptr_step = wmode_r[WM_INCR] ? ptr_r + 16'd1 : ptr_r;
  assign cur_idx  = idx_r[OSC_AW-1:0];
  assign p_idx    = cur_idx ^ OSC_AW'(1);
  assign has_p    = 6'(p_idx) < 6'(NUM_OSC);
  assign osc_ok   = 6'(ptr_r[4:0]) < 6'(NUM_OSC);
  assign heavy    = 6'(idx_r) == (act_cnt_r - 6'd1);
  assign mode0    = w_r.ctl[2:1];
  assign emode    = (mode0 == MODE_SYNC) ? MODE_FREE : mode0;
  assign b_s      = signed'(snd_q ^ 8'h80);
  assign prod_c   = 17'(b_s) * 17'($signed({1'b0, w_r.vol}));

  // visible oscillators, and the lowest one with a pending interrupt
  always_comb begin
    claim_hit = 1'b0;
    claim_idx = '0;
    for (int k = 0; k < NUM_OSC; k++) begin
      vis_mask[k] = 6'(k) < n_vis;
    end
    claim_mask = irq_r & vis_mask;
    for (int k = NUM_OSC - 1; k >= 0; k--) begin
      if (claim_mask[k]) begin
        claim_hit = 1'b1;
        claim_idx = OSC_AW'(k);
      end
    end
  end

  // stop rules for the current oscillator: halt or wrap, swap release,
  // interrupt raise
  always_comb begin
    logic [7:0]  ctl1;
    logic [1:0]  nsub;
    logic        nctl3;
    ctl1  = w_r.ctl;
    nsub  = 2'd0;
    nctl3 = from_reg_r ? din_r[CTL_IRQ_EN] : w_r.ctl[CTL_IRQ_EN];
    if (emode != MODE_FREE || !at_end_r) begin
      ctl1[CTL_HALT] = 1'b1;
    end else begin
      nsub = 2'd1;
    end
    if (emode != MODE_SWAP && pmode_r == MODE_SWAP && !idx_r[0]) begin
      ctl1[CTL_HALT] = 1'b0;
      nsub = nsub + 2'd1;
    end
    unique case (nsub)
      2'd0:    fin_phase = w_r.phase;
      2'd1:    fin_phase = w_r.phase - calc.span;
      default: fin_phase = w_r.phase - (calc.span << 1);
    endcase
    fin_ctl = from_reg_r ? din_r : ctl1;
    fin_irq = w_r.ctl[CTL_IRQ_EN] && !(at_end_r && !nctl3);
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    ptr_nxt      = ptr_r;
    wmode_nxt    = wmode_r;
    latch_nxt    = latch_r;
    status_nxt   = status_r;
    enable_nxt   = enable_r;
    act_cnt_nxt  = act_cnt_r;
    irq_nxt      = irq_r;
    osc_vld_nxt  = osc_vld_r;
    out_valid_nxt = out_valid_r;
    req_nxt      = req_r;
    din_nxt      = din_r;
    reg_nxt      = reg_r;
    idx_nxt      = idx_r;
    w_nxt        = w_r;
    pos_end_nxt  = pos_end_r;
    byte_nxt     = byte_r;
    prod_nxt     = prod_r;
    mix_nxt      = mix_r;
    res_rd_nxt   = res_rd_r;
    at_end_nxt   = at_end_r;
    from_reg_nxt = from_reg_r;
    pmode_nxt    = pmode_r;
    out_rd_nxt   = out_rd_r;
    out_mix_nxt  = out_mix_r;
    out_sv_nxt   = out_sv_r;
    out_irq_nxt  = out_irq_r;
    osc_re       = 1'b0;
    osc_raddr    = cur_idx;
    osc_we       = 1'b0;
    osc_waddr    = cur_idx;
    osc_wdata    = w_r;
    snd_re       = 1'b0;
    snd_raddr    = snd_addr({1'b0, ptr_r});
    snd_we       = 1'b0;
    snd_waddr    = snd_addr({1'b0, ptr_r});
    snd_wdata    = din_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        // sweep sound RAM to zero
        snd_we      = 1'b1;
        snd_waddr   = clr_cnt_r;
        snd_wdata   = 8'h00;
        clr_cnt_nxt = clr_cnt_r + SRAM_AW'(1);
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          din_nxt    = in_data_in;
          reg_nxt    = ptr_r[7:0];
          res_rd_nxt = 8'h00;
          mix_nxt    = '0;
          state_nxt  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_DONE;
        idx_nxt   = (OSC_AW + 1)'(ptr_r[4:0] & 5'(NUM_OSC - 1));
        unique case (req_r)
          REQ_MODE: begin
            wmode_nxt = din_r[6:0];
            if (!din_r[WM_RAM]) begin
              ptr_nxt[15:8] = 8'h00;
            end
          end
          REQ_PTR_LO: begin
            ptr_nxt[7:0] = din_r;
          end
          REQ_PTR_HI: begin
            ptr_nxt[15:8] = wmode_r[WM_RAM] ? din_r : 8'h00;
          end
          REQ_WRITE: begin
            latch_nxt = din_r;
            ptr_nxt   = ptr_step;
            if (wmode_r[WM_RAM]) begin
              snd_we = 1'b1;
            end else if (reg_r[7:5] != GRP_GLOBAL) begin
              if (osc_ok) begin
                osc_re    = 1'b1;
                osc_raddr = ptr_r[OSC_AW-1:0];
                state_nxt = ST_RW_GOT;
              end
            end else if (reg_r == REG_ENABLE) begin
              enable_nxt  = din_r;
              act_cnt_nxt = {1'b0, din_r[5:1]} + 6'd1;
            end
          end
          REQ_READ: begin
            res_rd_nxt = latch_r;
            ptr_nxt    = ptr_step;
            if (wmode_r[WM_RAM]) begin
              snd_re    = 1'b1;
              state_nxt = ST_BUS_RD;
            end else if (reg_r[7:5] != GRP_GLOBAL) begin
              if (osc_ok) begin
                osc_re    = 1'b1;
                osc_raddr = ptr_r[OSC_AW-1:0];
                state_nxt = ST_RR_GOT;
              end else begin
                latch_nxt = 8'h00;
              end
            end else if (reg_r == REG_IRQ_CLAIM) begin
              if (claim_hit) begin
                latch_nxt  = {2'b00, 5'(claim_idx), 1'b0} | 8'h41;
                status_nxt = {2'b00, 5'(claim_idx), 1'b0} | 8'h80;
                irq_nxt[claim_idx] = 1'b0;
              end else begin
                latch_nxt = status_r | 8'h41;
              end
            end else if (reg_r == REG_ENABLE) begin
              latch_nxt = enable_r;
            end else begin
              latch_nxt = 8'h00;
            end
          end
          REQ_SCAN: begin
            idx_nxt   = '0;
            state_nxt = ST_SC_RD;
          end
          default: begin
          end
        endcase
      end

      ST_BUS_RD: begin
        latch_nxt = snd_q;
        state_nxt = ST_DONE;
      end

      ST_RR_GOT: begin
        unique case (reg_r[7:5])
          GRP_FREQ_LO: latch_nxt = osc_q.freq[7:0];
          GRP_FREQ_HI: latch_nxt = osc_q.freq[15:8];
          GRP_VOLUME:  latch_nxt = osc_q.vol;
          GRP_LAST:    latch_nxt = osc_q.last;
          GRP_BASE:    latch_nxt = osc_q.base[15:8];
          GRP_CONTROL: latch_nxt = osc_q.ctl;
          GRP_SIZE:    latch_nxt = {1'b0, osc_q.base[16], osc_q.size, osc_q.res};
          default:     latch_nxt = 8'h00;
        endcase
        state_nxt = ST_DONE;
      end

      ST_RW_GOT: begin
        w_nxt     = osc_q;
        state_nxt = ST_DONE;
        unique case (reg_r[7:5])
          GRP_FREQ_LO: w_nxt.freq[7:0]  = din_r;
          GRP_FREQ_HI: w_nxt.freq[15:8] = din_r;
          GRP_VOLUME:  w_nxt.vol = din_r;
          GRP_BASE:    w_nxt.base = {osc_q.base[16], din_r, 8'h00};
          GRP_SIZE: begin
            w_nxt.base[16] = din_r[6];
            w_nxt.size     = din_r[5:3];
            w_nxt.res      = din_r[2:0];
          end
          GRP_CONTROL: begin
            if (osc_q.ctl[CTL_HALT] && !din_r[CTL_HALT]) begin
              w_nxt.phase = '0;
            end
            w_nxt.ctl = din_r;
          end
          default: begin
          end
        endcase
        if (reg_r[7:5] == GRP_CONTROL && !osc_q.ctl[CTL_HALT] && din_r[CTL_HALT] &&
            din_r[1]) begin
          // halting with a one-shot or swap mode applies the stop rules first
          w_nxt        = osc_q;
          at_end_nxt   = 1'b1;
          from_reg_nxt = 1'b1;
          state_nxt    = ST_SP_M;
        end else begin
          osc_we    = 1'b1;
          osc_wdata = w_nxt;
          osc_vld_nxt[cur_idx] = 1'b1;
        end
      end

      ST_SC_RD: begin
        if (6'(idx_r) == n_vis) begin
          state_nxt = ST_DONE;
        end else begin
          osc_re    = 1'b1;
          state_nxt = ST_SC_GOT;
        end
      end

      ST_SC_GOT: begin
        if (osc_q.ctl[CTL_HALT]) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SC_RD;
        end else begin
          w_nxt       = osc_q;
          w_nxt.phase = osc_q.phase + {16'h0000, osc_q.freq};
          pos_end_nxt = calc.pos_end;
          snd_re      = 1'b1;
          snd_raddr   = snd_addr(calc.addr);
          state_nxt   = ST_SC_BYTE;
        end
      end

      ST_SC_BYTE: begin
        w_nxt.last = snd_q;
        byte_nxt   = snd_q;
        prod_nxt   = prod_c;
        if (snd_q == 8'h00) begin
          // zero byte: halt through the stop rules
          at_end_nxt   = 1'b0;
          from_reg_nxt = 1'b0;
          state_nxt    = ST_SP_M;
        end else if (mode0 == MODE_SYNC && idx_r[0]) begin
          state_nxt = ((idx_r + 1'b1) < (OSC_AW + 1)'(NUM_OSC)) ? ST_SY_RD : ST_SC_END;
        end else begin
          state_nxt = ST_SC_MIX;
        end
      end

      ST_SC_MIX: begin
        mix_nxt   = mix_r + 22'(prod_r) + (heavy ? (22'(prod_r) <<< 1) : 22'sd0);
        state_nxt = ST_SC_END;
      end

      ST_SY_RD: begin
        osc_re    = 1'b1;
        osc_raddr = cur_idx + OSC_AW'(1);
        state_nxt = ST_SY_GOT;
      end

      ST_SY_GOT: begin
        // modulator byte becomes the next oscillator's volume when it is running
        if (!osc_q.ctl[CTL_HALT]) begin
          osc_we        = 1'b1;
          osc_waddr     = cur_idx + OSC_AW'(1);
          osc_wdata     = osc_q;
          osc_wdata.vol = byte_r;
          osc_vld_nxt[cur_idx + OSC_AW'(1)] = 1'b1;
        end
        state_nxt = ST_SC_END;
      end

      ST_SC_END: begin
        if (pos_end_r) begin
          at_end_nxt   = 1'b1;
          from_reg_nxt = 1'b0;
          state_nxt    = ST_SP_M;
        end else begin
          osc_we    = 1'b1;
          osc_vld_nxt[cur_idx] = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SC_RD;
        end
      end

      ST_SP_M: begin
        // sync on an even oscillator resets the odd one below it
        if (mode0 == MODE_SYNC && !idx_r[0] && idx_r != '0) begin
          osc_re    = 1'b1;
          osc_raddr = cur_idx - OSC_AW'(1);
          state_nxt = ST_SP_GOTM;
        end else begin
          state_nxt = ST_SP_P;
        end
      end

      ST_SP_GOTM: begin
        if (!osc_q.ctl[CTL_HALT]) begin
          osc_we          = 1'b1;
          osc_waddr       = cur_idx - OSC_AW'(1);
          osc_wdata       = osc_q;
          osc_wdata.phase = '0;
          osc_vld_nxt[cur_idx - OSC_AW'(1)] = 1'b1;
        end
        state_nxt = ST_SP_P;
      end

      ST_SP_P: begin
        pmode_nxt = MODE_FREE;
        if (has_p && (!idx_r[0] || emode == MODE_SWAP)) begin
          osc_re    = 1'b1;
          osc_raddr = p_idx;
          state_nxt = ST_SP_GOTP;
        end else begin
          state_nxt = ST_SP_FIN;
        end
      end

      ST_SP_GOTP: begin
        pmode_nxt = osc_q.ctl[2:1];
        if (emode == MODE_SWAP) begin
          // hand over to the partner
          osc_we        = 1'b1;
          osc_waddr     = p_idx;
          osc_wdata     = osc_q;
          osc_wdata.ctl[CTL_HALT] = 1'b0;
          osc_wdata.phase = '0;
          osc_vld_nxt[p_idx] = 1'b1;
        end
        state_nxt = ST_SP_FIN;
      end

      ST_SP_FIN: begin
        osc_we          = 1'b1;
        osc_wdata       = w_r;
        osc_wdata.ctl   = fin_ctl;
        osc_wdata.phase = fin_phase;
        osc_vld_nxt[cur_idx] = 1'b1;
        if (fin_irq) begin
          irq_nxt[cur_idx] = 1'b1;
        end
        if (from_reg_r) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SC_RD;
        end
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_sv_nxt    = (req_r == REQ_SCAN);
          out_mix_nxt   = (req_r == REQ_SCAN) ? mix_r : 22'sd0;
          out_irq_nxt   = |(irq_r & vis_mask);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      ptr_r       <= 16'h0000;
      wmode_r     <= 7'h00;
      latch_r     <= 8'h00;
      status_r    <= 8'hFF;
      enable_r    <= 8'h00;
      act_cnt_r   <= 6'd1;
      irq_r       <= '0;
      osc_vld_r   <= '0;
      osc_rvld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ptr_r       <= ptr_nxt;
      wmode_r     <= wmode_nxt;
      latch_r     <= latch_nxt;
      status_r    <= status_nxt;
      enable_r    <= enable_nxt;
      act_cnt_r   <= act_cnt_nxt;
      irq_r       <= irq_nxt;
      osc_vld_r   <= osc_vld_nxt;
      if (osc_re) begin
        osc_rvld_r <= osc_vld_r[osc_raddr];
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    din_r      <= din_nxt;
    reg_r      <= reg_nxt;
    idx_r      <= idx_nxt;
    w_r        <= w_nxt;
    pos_end_r  <= pos_end_nxt;
    byte_r     <= byte_nxt;
    prod_r     <= prod_nxt;
    mix_r      <= mix_nxt;
    res_rd_r   <= res_rd_nxt;
    at_end_r   <= at_end_nxt;
    from_reg_r <= from_reg_nxt;
    pmode_r    <= pmode_nxt;
    out_rd_r   <= out_rd_nxt;
    out_mix_r  <= out_mix_nxt;
    out_sv_r   <= out_sv_nxt;
    out_irq_r  <= out_irq_nxt;
  end

  // checks
  `WTS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != ST_IDLE, "stayed idle")
  `WTS_ASSERT_SAME(a_osc_port_clash, osc_we && osc_re, osc_waddr != osc_raddr, "port clash")
  `WTS_ASSERT_SAME(a_bus_mix, out_valid && !out_sample_valid, out_mix_sample == '0, "bus mix")
  `WTS_ASSERT_SAME(a_scan_rd, out_valid && out_sample_valid, out_read_data == '0, "scan read")

endmodule

`default_nettype wire

// ===== src/wts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/wts_addr_gen.sv =====
// ----------------------------------------------------------------------------
// Wavetable address generator
// Table position, sound RAM address, end-of-table flag and loop span.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_addr_gen (
  input  wire wts_pkg::osc_rec_t rec,
  output wts_pkg::wts_calc_t     calc
);

  import wts_pkg::*;

  logic [4:0]  sh;
  logic [15:0] lenm1;
  logic [31:0] pos;
  logic [15:0] off;
  logic [16:0] start;

  assign sh    = 5'd9 + {2'b00, rec.res} - {2'b00, rec.size};
  assign lenm1 = (16'd256 << rec.size) - 16'd1;
  assign pos   = rec.phase >> sh;
  assign off   = pos[15:0] & lenm1;
  assign start = rec.base & ~{1'b0, lenm1};

  assign calc.addr    = start + {1'b0, off};
  assign calc.pos_end = pos >= {16'h0000, lenm1};
  assign calc.span    = {16'h0000, lenm1} << sh;

endmodule

`default_nettype wire

// ===== dv/wavetable_sound_chip_test.sv =====
// ----------------------------------------------------------------------------
// Wavetable sound chip testbench
// Drives window accesses and scan ticks through the valid/ready input channel,
// predicts every result word from a behavioural model of the oscillators, the
// sound RAM and the register page, and checks each word as it leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_sound_chip_test;
  import wts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]         rdata;
    logic signed [21:0] mix;
    logic               svalid;
    logic               irq;
  } result_t;

  int fail_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Behavioural model of the chip, plus the queue of predicted words.
  class chip_scoreboard;
    logic [7:0]  sram [RAM_DEPTH];
    logic [15:0] freq [NUM_OSC];
    logic [7:0]  vol [NUM_OSC];
    logic [16:0] base [NUM_OSC];
    logic [7:0]  ctl [NUM_OSC];
    logic [2:0]  size [NUM_OSC];
    logic [2:0]  res [NUM_OSC];
    logic [31:0] phase [NUM_OSC];
    logic [7:0]  last [NUM_OSC];
    bit          flag [NUM_OSC];
    logic [15:0] ptr;
    logic [6:0]  wmode;
    logic [7:0]  latch;
    logic [7:0]  irq_status;
    logic [7:0]  enable;
    int          active;
    result_t     pending[$];

    function new();
      foreach (sram[i]) sram[i] = 0;
      for (int i = 0; i < NUM_OSC; i++) begin
        freq[i] = 0; vol[i] = 0; base[i] = 0; ctl[i] = 0; size[i] = 0;
        res[i] = 0; phase[i] = 0; last[i] = 0; flag[i] = 0;
      end
      ptr = 0; wmode = 0; latch = 0; irq_status = 8'hFF; enable = 0; active = 1;
    endfunction

    function int visits();
      return active < NUM_OSC ? active : NUM_OSC;
    endfunction

    function logic [31:0] span(int i);
      int sh;
      sh = 9 + res[i] - size[i];
      return ((32'd256 << size[i]) - 1) << sh;
    endfunction

    function void halt_osc(int i, bit at_end, logic [7:0] new_ctl);
      int p;
      bit has_p;
      logic [1:0] m, pm;
      p = i ^ 1;
      has_p = p < NUM_OSC;
      m = ctl[i][2:1];
      pm = has_p ? ctl[p][2:1] : MODE_FREE;
      if (m == MODE_SYNC) begin
        if (i[0] == 0 && i > 0 && !ctl[i-1][CTL_HALT]) phase[i-1] = 0;
        m = MODE_FREE;
      end
      if (m != MODE_FREE || !at_end) ctl[i][CTL_HALT] = 1;
      else phase[i] -= span(i);
      if (m == MODE_SWAP) begin
        if (has_p) begin
          ctl[p][CTL_HALT] = 0;
          phase[p] = 0;
        end
      end else if (pm == MODE_SWAP && i[0] == 0) begin
        ctl[i][CTL_HALT] = 0;
        phase[i] -= span(i);
      end
      if (ctl[i][CTL_IRQ_EN]) begin
        if (at_end && !new_ctl[CTL_IRQ_EN]) return;
        flag[i] = 1;
      end
    endfunction

    function logic [7:0] reg_rd(logic [7:0] r);
      int i;
      logic [7:0] v;
      i = r[4:0];
      if (r < REG_IRQ_CLAIM) begin
        if (i >= NUM_OSC) return 0;
        case (r[7:5])
          GRP_FREQ_LO: return freq[i][7:0];
          GRP_FREQ_HI: return freq[i][15:8];
          GRP_VOLUME:  return vol[i];
          GRP_LAST:    return last[i];
          GRP_BASE:    return base[i][15:8];
          GRP_CONTROL: return ctl[i];
          default:     return {1'b0, base[i][16], size[i], res[i]};
        endcase
      end
      if (r == REG_IRQ_CLAIM) begin
        v = irq_status;
        for (int k = 0; k < visits(); k++)
          if (flag[k]) begin
            v = 8'(k << 1);
            irq_status = v | 8'h80;
            flag[k] = 0;
            break;
          end
        return v | 8'h41;
      end
      if (r == REG_ENABLE) return enable;
      return 0;
    endfunction

    function void reg_wr(logic [7:0] r, logic [7:0] v);
      int i;
      i = r[4:0];
      if (r < REG_IRQ_CLAIM) begin
        if (i >= NUM_OSC) return;
        case (r[7:5])
          GRP_FREQ_LO: freq[i][7:0] = v;
          GRP_FREQ_HI: freq[i][15:8] = v;
          GRP_VOLUME:  vol[i] = v;
          GRP_LAST:    ;
          GRP_BASE:    base[i][15:8] = v;
          GRP_CONTROL: begin
            if (ctl[i][CTL_HALT] && !v[0]) phase[i] = 0;
            if (!ctl[i][CTL_HALT] && v[0] && v[1]) halt_osc(i, 1, v);
            ctl[i] = v;
          end
          default: begin
            base[i][16] = v[6];
            size[i] = v[5:3];
            res[i] = v[2:0];
          end
        endcase
      end else if (r == REG_ENABLE) begin
        enable = v;
        active = v[5:1] + 1;
      end
    endfunction

    function int scan();
      int mix, sh, s;
      logic [31:0] len, start, pos, off;
      logic [7:0] b;
      mix = 0;
      for (int i = 0; i < visits(); i++) begin
        if (ctl[i][CTL_HALT]) continue;
        sh = 9 + res[i] - size[i];
        len = 32'd256 << size[i];
        start = {15'd0, base[i]} & ~(len - 1) & 32'h1FFFF;
        pos = phase[i] >> sh;
        off = pos & (len - 1);
        phase[i] += freq[i];
        b = sram[(start + off) % RAM_DEPTH];
        last[i] = b;
        if (b == 0) begin
          halt_osc(i, 0, ctl[i]);
          continue;
        end
        if (ctl[i][2:1] == MODE_SYNC && i[0]) begin
          if (i + 1 < NUM_OSC && !ctl[i+1][CTL_HALT]) vol[i+1] = b;
        end else begin
          s = (int'(b) - 128) * int'(vol[i]);
          mix += (i == active - 1) ? 3 * s : s;
        end
        if (pos >= len - 1) halt_osc(i, 1, ctl[i]);
      end
      return mix;
    endfunction

    // Note an accepted input word and queue the word it must produce.
    function void note_request(logic [2:0] kind, logic [7:0] d);
      result_t r;
      r = '{8'd0, 22'sd0, 1'b0, 1'b0};
      case (kind)
        REQ_MODE: begin
          wmode = d[6:0];
          if (!wmode[WM_RAM]) ptr[15:8] = 0;
        end
        REQ_PTR_LO: ptr[7:0] = d;
        REQ_PTR_HI: begin
          ptr[15:8] = d;
          if (!wmode[WM_RAM]) ptr[15:8] = 0;
        end
        REQ_WRITE: begin
          latch = d;
          if (wmode[WM_RAM]) sram[ptr % RAM_DEPTH] = d;
          else reg_wr(ptr[7:0], d);
          if (wmode[WM_INCR]) ptr++;
        end
        REQ_READ: begin
          r.rdata = latch;
          latch = wmode[WM_RAM] ? sram[ptr % RAM_DEPTH] : reg_rd(ptr[7:0]);
          if (wmode[WM_INCR]) ptr++;
        end
        REQ_SCAN: begin
          r.mix = scan();
          r.svalid = 1;
        end
        default: ;
      endcase
      for (int k = 0; k < visits(); k++) if (flag[k]) r.irq = 1;
      pending.push_back(r);
    endfunction

    // Compare a result word with the oldest prediction.
    task check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.rdata !== w.rdata) report_mismatch("read_data", got.rdata, w.rdata);
      if (got.mix !== w.mix) report_mismatch("mix_sample", got.mix, w.mix);
      if (got.svalid !== w.svalid)
        report_mismatch("sample_valid", got.svalid, w.svalid);
      if (got.irq !== w.irq) report_mismatch("irq_active", got.irq, w.irq);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_req_type = 0;
  logic [7:0]  in_data_in = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_read_data;
  logic signed [21:0] out_mix_sample;
  logic        out_sample_valid;
  logic        out_irq_active;

  wavetable_sound_chip dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  chip_scoreboard sb = new();
  int idle_pct = 0;   // sender gap chance, percent
  int stall_pct = 0;  // receiver stall chance, percent
  int hold_off = 0;   // cycles of forced receiver back-pressure
  bit done = 0;

  // Send one word; returns once the block has taken it. Valid stays high
  // into the next word unless a gap is drawn.
  task automatic send_word(input logic [2:0] kind, input logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= kind;
    in_data_in <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, d);
  endtask

  // Receiver: check accepted words, stall at random or through a hold-off.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_read_data, out_mix_sample, out_sample_valid,
                        out_irq_active});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_ptr(input logic [15:0] a);
    send_word(REQ_PTR_HI, a[15:8]);
    send_word(REQ_PTR_LO, a[7:0]);
  endtask

  task automatic reg_write(input logic [7:0] r, input logic [7:0] v);
    send_word(REQ_MODE, 8'h00);
    send_word(REQ_PTR_LO, r);
    send_word(REQ_WRITE, v);
  endtask

  // Fill a small wave table in RAM with random bytes, zero now and then.
  task automatic load_table(input logic [15:0] a, input int n);
    send_word(REQ_MODE, 8'h60);
    set_ptr(a);
    for (int k = 0; k < n; k++)
      send_word(REQ_WRITE, ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom));
  endtask

  // Program one oscillator with random but sane settings.
  task automatic setup_osc(input int i);
    logic [7:0] c;
    reg_write(8'(8'h00 + i), 8'($urandom));
    reg_write(8'(8'h20 + i), 8'($urandom_range(3)));
    reg_write(8'(8'h40 + i), 8'($urandom));
    reg_write(8'(8'h80 + i), 8'($urandom));
    reg_write(8'(8'hC0 + i), {1'b0, 1'($urandom), 3'($urandom_range(1)), 3'($urandom)});
    c = {4'd0, 1'($urandom), 2'($urandom), 1'b0};
    reg_write(8'(8'hA0 + i), c);
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) send_word(REQ_SCAN, 8'($urandom));
    else if (pick < 50) send_word(REQ_READ, 8'($urandom));
    else if (pick < 65) reg_write(8'($urandom), 8'($urandom));
    else if (pick < 75) begin
      send_word(REQ_MODE, 8'($urandom));
      send_word(REQ_READ, 8'($urandom));
    end else if (pick < 85) send_word(REQ_READ, 0);
    else if (pick < 92) send_word(3'($urandom_range(7)), 8'($urandom));
    else begin
      reg_write(REG_IRQ_CLAIM, 0);
      send_word(REQ_MODE, 8'h00);
      send_word(REQ_PTR_LO, REG_IRQ_CLAIM);
      send_word(REQ_READ, 0);
      send_word(REQ_READ, 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed: window modes, pointer extremes, RAM writes and reads.
    send_word(REQ_MODE, 8'hFF);
    set_ptr(16'hFFFF);
    send_word(REQ_WRITE, 8'hFF);
    send_word(REQ_WRITE, 8'h00);     // auto-increment wraps the pointer
    set_ptr(16'hFFFF);
    send_word(REQ_READ, 0);
    send_word(REQ_READ, 0);
    send_word(3'd6, 8'hAA);          // unused codes
    send_word(3'd7, 8'h55);
    send_word(REQ_MODE, 8'h20);      // register window, auto-increment
    send_word(REQ_PTR_LO, 8'hFF);
    send_word(REQ_WRITE, 8'h12);     // carries into bit 8
    send_word(REQ_READ, 0);
    send_word(REQ_PTR_HI, 8'hFF);    // cleared in register window
    reg_write(8'h60, 8'h77);         // read-only last byte
    reg_write(8'hE2, 8'h99);         // global address with no register
    reg_write(8'hE3, 8'h99);         // unused address
    reg_write(REG_ENABLE, 8'hFF);    // all oscillators enabled
    send_word(REQ_PTR_LO, REG_IRQ_CLAIM);
    send_word(REQ_READ, 0);          // claim with nothing pending
    send_word(REQ_READ, 0);
    send_word(REQ_SCAN, 0);

    // Random: load tables, program oscillators, then mixed traffic.
    for (int phase_n = 0; phase_n < 4; phase_n++) begin
      case (phase_n)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      load_table(16'($urandom_range(255)) << 8, 64);
      for (int k = 0; k < 4; k++) setup_osc($urandom_range(NUM_OSC - 1));
      reg_write(REG_ENABLE, (phase_n == 3) ? 8'h3E : 8'($urandom_range(15)) << 1);
      if (phase_n == 1) hold_off <= 400;
      for (int k = 0; k < 120; k++) random_word();
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    done = 1;
    if (fail_count == 0) $display("wavetable_sound_chip_test: PASS");
    else $display("wavetable_sound_chip_test: FAIL");
    $finish;
  end

  // Timeout that allows for the clearing pass after reset plus slow scans with stalls.
  initial begin
    #50ms;
    if (!done) $display("wavetable_sound_chip_test: FAIL");
    $finish;
  end
endmodule

`default_nettype wire

// ===== wavetable_sound_chip.f =====
+incdir+src
src/wts_pkg.sv
src/wts_ram.sv
src/wts_addr_gen.sv
src/wavetable_sound_chip.sv
dv/wavetable_sound_chip_test.sv
